[rtl/ihls_seg_pkg.sv]
package ihls_seg_pkg;

  // datapath widths
  localparam int CORDIC_W  = 28;
  localparam int Z_W       = 26;
  localparam int ANGLE_W   = 24;
  localparam int ATAN_W    = 22;
  localparam int TABLE_LEN = 24;

  // angle units are 2*pi / 2^24
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd4194304;
  localparam logic signed [Z_W-1:0] HALF_TURN    = 26'sd8388608;
  localparam logic [ANGLE_W:0]      TURN_UNITS   = 25'd16777216;

  // sqrt(3) in Q16 and luminance weights in Q0.16
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  localparam logic [15:0] LUM_R     = 16'd13933;
  localparam logic [15:0] LUM_G     = 16'd46871;
  localparam logic [15:0] LUM_B     = 16'd4732;

  localparam logic [7:0] HUE_PI = 8'd127;

  // register reset values
  localparam logic [7:0] RST_RED_GATE     = 8'd180;
  localparam logic [7:0] RST_RED_HUE_LOW  = 8'd15;
  localparam logic [7:0] RST_RED_HUE_HIGH = 8'd183;
  localparam logic [7:0] RST_RED_SAT_MIN  = 8'd16;
  localparam logic [7:0] RST_BLUE_HUE_MIN = 8'd143;
  localparam logic [7:0] RST_BLUE_SAT_MIN = 8'd36;

  typedef enum logic [2:0] {
    REG_RED_GATE     = 3'd0,
    REG_RED_HUE_LOW  = 3'd1,
    REG_RED_HUE_HIGH = 3'd2,
    REG_RED_SAT_MIN  = 3'd3,
    REG_BLUE_HUE_MIN = 3'd4,
    REG_BLUE_SAT_MIN = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [Z_W-1:0]      z;
  } vec_t;

  // values that ride along with the rotation
  typedef struct packed {
    logic [7:0] sat;
    logic [7:0] lum;
    logic       flat;
    logic       neg_x;
    logic       b_gt_g;
  } side_t;

  typedef struct packed {
    vec_t  vec;
    side_t side;
  } stage_t;

  typedef struct packed {
    logic [7:0] red_hue_low;
    logic [7:0] red_hue_high;
    logic [7:0] red_sat_min;
    logic [7:0] blue_hue_min;
    logic [7:0] blue_sat_min;
  } mask_cfg_t;

  // atan(2^-i) in angle units, rounded
  function automatic logic [ATAN_W-1:0] atan_units(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      5'd18:   v = 22'd10;
      5'd19:   v = 22'd5;
      5'd20:   v = 22'd3;
      5'd21:   v = 22'd1;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/rgb_to_ihls_color_segmenter_top.sv]
// channel   direction  handshake                  payload
// pixel     in         pixel_valid / pixel_stall  red, green, blue
// result    out        result_valid / result_stall saturation, luminance, hue, masks
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pixel per cycle while the result side does not stall; a result passes
// through a front stage, one cordic cell per micro-rotation, and the output
// register.
// rst is synchronous and clears all valid bits and loads register defaults.
// every stage holds its item while the stage after it is full and stalled,
// so bubbles close up; cfg_ready is always high.
module rgb_to_ihls_color_segmenter_top #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] saturation,
  output logic [7:0] luminance,
  output logic [7:0] hue,
  output logic       red_mask,
  output logic       blue_mask,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import ihls_seg_pkg::*;

  // no more micro-rotations than the arctangent table holds
  localparam int N = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

  logic [7:0] red_gate;
  mask_cfg_t  mask_cfg;

  logic       stage_valid [N+1];
  logic       stage_ready [N+1];
  stage_t     stage_data  [N+1];
  logic       front_ready;
  logic       back_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gate              <= RST_RED_GATE;
      mask_cfg.red_hue_low  <= RST_RED_HUE_LOW;
      mask_cfg.red_hue_high <= RST_RED_HUE_HIGH;
      mask_cfg.red_sat_min  <= RST_RED_SAT_MIN;
      mask_cfg.blue_hue_min <= RST_BLUE_HUE_MIN;
      mask_cfg.blue_sat_min <= RST_BLUE_SAT_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_RED_GATE:     red_gate              <= cfg_data;
        REG_RED_HUE_LOW:  mask_cfg.red_hue_low  <= cfg_data;
        REG_RED_HUE_HIGH: mask_cfg.red_hue_high <= cfg_data;
        REG_RED_SAT_MIN:  mask_cfg.red_sat_min  <= cfg_data;
        REG_BLUE_HUE_MIN: mask_cfg.blue_hue_min <= cfg_data;
        REG_BLUE_SAT_MIN: mask_cfg.blue_sat_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pixel_stall = !front_ready;

  // gating, saturation, luminance, starting vector
  ihls_seg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel_valid),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .red_gate   (red_gate),
    .up_ready   (front_ready),
    .down_ready (stage_ready[0]),
    .valid      (stage_valid[0]),
    .data       (stage_data[0])
  );

  // chain of cordic cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    ihls_seg_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (stage_valid[k]),
      .in_data    (stage_data[k]),
      .up_ready   (stage_ready[k]),
      .down_ready (stage_ready[k+1]),
      .valid      (stage_valid[k+1]),
      .data       (stage_data[k+1])
    );
  end

  assign stage_ready[N] = back_ready;

  // hue scaling, masks, output register
  ihls_seg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stage_valid[N]),
    .in_data      (stage_data[N]),
    .cfg          (mask_cfg),
    .up_ready     (back_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .saturation   (saturation),
    .luminance    (luminance),
    .hue          (hue),
    .red_mask     (red_mask),
    .blue_mask    (blue_mask)
  );

endmodule

[rtl/ihls_seg_front.sv]
module ihls_seg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            red_gate,
  output logic                  up_ready,
  input  logic                  down_ready,
  output logic                  valid,
  output ihls_seg_pkg::stage_t  data
);
  import ihls_seg_pkg::*;

  logic [7:0]                 rg, gg, bg, mx, mn;
  logic [23:0]                lum_sum;
  logic signed [9:0]          x_small;
  logic signed [8:0]          d;
  logic [7:0]                 ad;
  logic [24:0]                y_mag;
  logic signed [CORDIC_W-1:0] x0, y0;
  stage_t                     data_next;

  // gate, saturation, luminance and the starting vector
  always_comb begin
    if (red < red_gate) begin
      rg = 8'd0;
      gg = 8'd0;
      bg = 8'd0;
    end else begin
      rg = red;
      gg = green;
      bg = blue;
    end
    mx = rg;
    if (gg > mx) mx = gg;
    if (bg > mx) mx = bg;
    mn = rg;
    if (gg < mn) mn = gg;
    if (bg < mn) mn = bg;
    lum_sum = 24'(LUM_R) * 24'(rg) + 24'(LUM_G) * 24'(gg) + 24'(LUM_B) * 24'(bg);
    x_small = $signed({1'b0, rg, 1'b0}) - $signed({2'b0, gg}) - $signed({2'b0, bg});
    d       = $signed({1'b0, gg}) - $signed({1'b0, bg});
    ad      = (d < 0) ? 8'(-d) : d[7:0];
    y_mag   = 25'(ad) * 25'(SQRT3_Q16);
    x0      = CORDIC_W'(x_small) <<< 16;
    y0      = $signed(CORDIC_W'(y_mag));

    data_next.side.sat    = mx - mn;
    data_next.side.lum    = lum_sum[23:16];
    data_next.side.flat   = (d == 9'sd0);
    data_next.side.neg_x  = (x_small < 0);
    data_next.side.b_gt_g = (bg > gg);
    // left half plane: turn by -pi/2 first
    if (x0 < 0) begin
      data_next.vec.x = y0;
      data_next.vec.y = -x0;
      data_next.vec.z = QUARTER_TURN;
    end else begin
      data_next.vec.x = x0;
      data_next.vec.y = y0;
      data_next.vec.z = '0;
    end
  end

  assign up_ready = !valid || down_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

[rtl/ihls_seg_cell.sv]
module ihls_seg_cell #(
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  ihls_seg_pkg::stage_t  in_data,
  output logic                  up_ready,
  input  logic                  down_ready,
  output logic                  valid,
  output ihls_seg_pkg::stage_t  data
);
  import ihls_seg_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_STEP =
    $signed(Z_W'(atan_units(5'(SHIFT))));

  logic signed [CORDIC_W-1:0] dx, dy;
  stage_t                     data_next;

  // one micro-rotation toward the x axis
  always_comb begin
    dx        = in_data.vec.y >>> SHIFT;
    dy        = in_data.vec.x >>> SHIFT;
    data_next = in_data;
    if (in_data.vec.y > 0) begin
      data_next.vec.x = in_data.vec.x + dx;
      data_next.vec.y = in_data.vec.y - dy;
      data_next.vec.z = in_data.vec.z + ATAN_STEP;
    end else if (in_data.vec.y < 0) begin
      data_next.vec.x = in_data.vec.x - dx;
      data_next.vec.y = in_data.vec.y + dy;
      data_next.vec.z = in_data.vec.z - ATAN_STEP;
    end
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

[rtl/ihls_seg_back.sv]
module ihls_seg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  ihls_seg_pkg::stage_t      in_data,
  input  ihls_seg_pkg::mask_cfg_t   cfg,
  output logic                      up_ready,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [7:0]                saturation,
  output logic [7:0]                luminance,
  output logic [7:0]                hue,
  output logic                      red_mask,
  output logic                      blue_mask
);
  import ihls_seg_pkg::*;

  logic [ANGLE_W-1:0] theta;
  logic [ANGLE_W:0]   angle_wide;
  logic [ANGLE_W-1:0] angle;
  logic [31:0]        prod;
  logic [7:0]         hue_next;
  logic               red_next, blue_next;

  // clamp theta, mirror for blue over green, scale to 0..254, form the masks
  always_comb begin
    if (in_data.vec.z < 0) begin
      theta = '0;
    end else if (in_data.vec.z > HALF_TURN) begin
      theta = ANGLE_W'(HALF_TURN);
    end else begin
      theta = in_data.vec.z[ANGLE_W-1:0];
    end
    angle_wide = in_data.side.b_gt_g ? (TURN_UNITS - {1'b0, theta}) : {1'b0, theta};
    angle      = (angle_wide >= TURN_UNITS) ? (ANGLE_W'(TURN_UNITS - 25'd1))
                                            : angle_wide[ANGLE_W-1:0];
    prod       = 32'(angle) * 32'd255;
    if (in_data.side.flat) begin
      hue_next = in_data.side.neg_x ? HUE_PI : 8'd0;
    end else begin
      hue_next = prod[31:24];
    end
    red_next  = (hue_next < cfg.red_hue_low) ||
                ((hue_next > cfg.red_hue_high) && (in_data.side.sat > cfg.red_sat_min));
    blue_next = (hue_next > cfg.blue_hue_min) && (in_data.side.sat > cfg.blue_sat_min);
  end

  assign up_ready = !result_valid || !result_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (up_ready) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      saturation <= in_data.side.sat;
      luminance  <= in_data.side.lum;
      hue        <= hue_next;
      red_mask   <= red_next;
      blue_mask  <= blue_next;
    end
  end

endmodule

[rtl/ihls_seg_checker.sv]
module ihls_seg_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] saturation,
  input logic [7:0] luminance,
  input logic [7:0] hue,
  input logic       red_mask,
  input logic       blue_mask
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(saturation) && $stable(luminance) && $stable(hue)
      && $stable(red_mask) && $stable(blue_mask))
    else $error("stalled item changed");

  // grey pixels carry hue zero and no blue mask
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    result_valid && (saturation == 8'd0) |-> (hue == 8'd0) && !blue_mask)
    else $error("grey item with nonzero hue or blue mask");

  // blue needs some saturation
  a_blue_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && blue_mask |-> (saturation != 8'd0) && (hue != 8'd0))
    else $error("blue mask on unsaturated item");

endmodule

bind rgb_to_ihls_color_segmenter_top ihls_seg_checker u_ihls_seg_checker (.*);
